### hw/rtl/sqm_pkg.sv
// ----------------------------------------------------------------------------
// Semaphore wait queue manager package
// Shared widths, operation and error codes, and the stored queue descriptor.
// ----------------------------------------------------------------------------
package sqm_pkg;

  localparam int OP_W     = 16;
  localparam int HANDLE_W = 5;
  localparam int PROC_W   = 7;
  localparam int LEN_W    = 7;
  localparam int ERR_W    = 2;

  localparam int DEF_NUM_SEMAPHORES = 16;
  localparam int DEF_NUM_PROCESSES  = 64;

  localparam logic [OP_W-1:0] OP_RESERVE = 16'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 16'd2;

  localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
  localparam logic [ERR_W-1:0] ERR_ARG  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OP   = 2'd2;

  localparam logic [LEN_W-1:0] LEN_MAX = 7'd127;

  typedef struct packed {
    logic [PROC_W-1:0] head;
    logic [PROC_W-1:0] tail;
    logic [LEN_W-1:0]  len;
  } sem_entry_t;

  typedef struct packed {
    logic [LEN_W-1:0]  waiters_left;
    logic [PROC_W-1:0] woken_process;
    logic              must_wait;
    logic [ERR_W-1:0]  error_code;
    logic              ok;
  } result_t;

endpackage

### hw/rtl/semaphore_wait_queue_manager_core.sv
// A result is registered in the lookup state for errors and for a release on an empty
// queue, and in the link or pop state for a reserve or a waking release. A new request is
// taken only when idle, after the descriptor memory read and, for a queue update, the
// second pass on the link memory; an unaccepted result holds the last step. Reset:
// control and the descriptor valid bits clear; queues read empty.
// ----------------------------------------------------------------------------
// Semaphore wait queue manager
// FIFO wait queues of process numbers per semaphore, kept as linked lists in
// a descriptor memory and a link memory.
// ----------------------------------------------------------------------------
module semaphore_wait_queue_manager_core #(
  parameter int NUM_SEMAPHORES = sqm_pkg::DEF_NUM_SEMAPHORES,
  parameter int NUM_PROCESSES  = sqm_pkg::DEF_NUM_PROCESSES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // req_type[15:0], sema_handle[20:16], caller_process[27:21], zero[31:28]
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // ok[0], error_code[2:1], must_wait[3], woken_process[10:4],
  // waiters_left[17:11], zero[23:18]
  output logic [23:0] m_tdata
);

  localparam int SW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
  localparam int NW = $clog2(NUM_PROCESSES);

  logic                          sem_re, sem_we, lnk_re, lnk_we;
  logic [SW-1:0]                 sem_raddr, sem_waddr;
  sqm_pkg::sem_entry_t           sem_rdata, sem_wdata;
  logic [NW-1:0]                 lnk_raddr, lnk_waddr;
  logic [sqm_pkg::PROC_W-1:0]    lnk_rdata, lnk_wdata;
  sqm_pkg::result_t              result;

  sqm_sem_store #(
    .NUM_SEMAPHORES(NUM_SEMAPHORES),
    .SW            (SW)
  ) u_sem_store (
    .clk  (clk),
    .rst  (rst),
    .re   (sem_re),
    .raddr(sem_raddr),
    .rdata(sem_rdata),
    .we   (sem_we),
    .waddr(sem_waddr),
    .wdata(sem_wdata)
  );

  sqm_link_store #(
    .NUM_PROCESSES(NUM_PROCESSES),
    .NW           (NW)
  ) u_link_store (
    .clk  (clk),
    .re   (lnk_re),
    .raddr(lnk_raddr),
    .rdata(lnk_rdata),
    .we   (lnk_we),
    .waddr(lnk_waddr),
    .wdata(lnk_wdata)
  );

  sqm_ctrl #(
    .NUM_SEMAPHORES(NUM_SEMAPHORES),
    .NUM_PROCESSES (NUM_PROCESSES),
    .SW            (SW),
    .NW            (NW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .req_type      (s_tdata[15:0]),
    .sema_handle   (s_tdata[20:16]),
    .caller_process(s_tdata[27:21]),
    .sem_re        (sem_re),
    .sem_raddr     (sem_raddr),
    .sem_rdata     (sem_rdata),
    .sem_we        (sem_we),
    .sem_waddr     (sem_waddr),
    .sem_wdata     (sem_wdata),
    .lnk_re        (lnk_re),
    .lnk_raddr     (lnk_raddr),
    .lnk_rdata     (lnk_rdata),
    .lnk_we        (lnk_we),
    .lnk_waddr     (lnk_waddr),
    .lnk_wdata     (lnk_wdata),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .result        (result)
  );

  assign m_tdata = {6'd0, result};

endmodule

### hw/rtl/sqm_sem_store.sv
// ----------------------------------------------------------------------------
// Semaphore descriptor store
// Head, tail and length per semaphore in one memory; valid bits make every
// entry read as an empty queue until it is first written.
// ----------------------------------------------------------------------------
module sqm_sem_store #(
  parameter int NUM_SEMAPHORES = sqm_pkg::DEF_NUM_SEMAPHORES,
  parameter int SW             = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                re,
  input  logic [SW-1:0]       raddr,
  output sqm_pkg::sem_entry_t rdata,
  input  logic                we,
  input  logic [SW-1:0]       waddr,
  input  sqm_pkg::sem_entry_t wdata
);

  sqm_pkg::sem_entry_t        mem [NUM_SEMAPHORES];
  logic [NUM_SEMAPHORES-1:0]  vld;
  sqm_pkg::sem_entry_t        rd_q;
  logic                       rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q   <= mem[raddr];
      rd_vld <= vld[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  assign rdata = rd_vld ? rd_q : '0;

endmodule

### hw/rtl/sqm_link_store.sv
// ----------------------------------------------------------------------------
// Waiter link store
// Next-waiter pointer per process, one write and one registered read port.
// ----------------------------------------------------------------------------
module sqm_link_store #(
  parameter int NUM_PROCESSES = sqm_pkg::DEF_NUM_PROCESSES,
  parameter int NW            = 6
) (
  input  logic                      clk,
  input  logic                      re,
  input  logic [NW-1:0]             raddr,
  output logic [sqm_pkg::PROC_W-1:0] rdata,
  input  logic                      we,
  input  logic [NW-1:0]             waddr,
  input  logic [sqm_pkg::PROC_W-1:0] wdata
);

  logic [sqm_pkg::PROC_W-1:0] mem [NUM_PROCESSES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/sqm_ctrl.sv
// ----------------------------------------------------------------------------
// Wait queue sequencer
// Reads the descriptor, follows or extends the list, writes back and holds
// the result register.
// ----------------------------------------------------------------------------
module sqm_ctrl #(
  parameter int NUM_SEMAPHORES = sqm_pkg::DEF_NUM_SEMAPHORES,
  parameter int NUM_PROCESSES  = sqm_pkg::DEF_NUM_PROCESSES,
  parameter int SW             = 4,
  parameter int NW             = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sqm_pkg::OP_W-1:0]      req_type,
  input  logic [sqm_pkg::HANDLE_W-1:0]  sema_handle,
  input  logic [sqm_pkg::PROC_W-1:0]    caller_process,
  output logic                          sem_re,
  output logic [SW-1:0]                 sem_raddr,
  input  sqm_pkg::sem_entry_t           sem_rdata,
  output logic                          sem_we,
  output logic [SW-1:0]                 sem_waddr,
  output sqm_pkg::sem_entry_t           sem_wdata,
  output logic                          lnk_re,
  output logic [NW-1:0]                 lnk_raddr,
  input  logic [sqm_pkg::PROC_W-1:0]    lnk_rdata,
  output logic                          lnk_we,
  output logic [NW-1:0]                 lnk_waddr,
  output logic [sqm_pkg::PROC_W-1:0]    lnk_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sqm_pkg::result_t              result
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_LINK = 4'b0100,
    ST_POP  = 4'b1000
  } state_t;

  state_t                        state, state_next;
  logic [sqm_pkg::OP_W-1:0]      op_q;
  logic                          h_ok_q;
  logic [SW-1:0]                 sidx_q;
  logic [sqm_pkg::PROC_W-1:0]    caller_q;
  sqm_pkg::result_t              res_next;
  logic                          res_load;
  logic                          res_free;
  logic                          h_in_ok;
  logic [sqm_pkg::HANDLE_W-1:0]  h_m1;
  logic [sqm_pkg::PROC_W-1:0]    caller_m1, head_m1, tail_m1;
  logic                          caller_ok, head_ok, tail_ok, nxt_ok;
  logic [sqm_pkg::LEN_W-1:0]     len_inc, len_dec;
  sqm_pkg::sem_entry_t           ent;

  function automatic logic proc_ok(input logic [sqm_pkg::PROC_W-1:0] p);
    return (p != '0) && (32'(p) <= 32'(NUM_PROCESSES));
  endfunction

  assign ent       = sem_rdata;
  assign res_free  = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && !rst;
  assign h_in_ok   = (sema_handle != '0) && (32'(sema_handle) <= 32'(NUM_SEMAPHORES));
  assign h_m1      = sema_handle - sqm_pkg::HANDLE_W'(1);
  assign caller_m1 = caller_q - sqm_pkg::PROC_W'(1);
  assign head_m1   = ent.head - sqm_pkg::PROC_W'(1);
  assign tail_m1   = ent.tail - sqm_pkg::PROC_W'(1);
  assign caller_ok = proc_ok(caller_q);
  assign head_ok   = proc_ok(ent.head);
  assign tail_ok   = proc_ok(ent.tail);
  assign nxt_ok    = proc_ok(lnk_rdata);
  assign len_inc   = (ent.len == sqm_pkg::LEN_MAX) ? ent.len : ent.len + 1'b1;
  assign len_dec   = (ent.len == '0) ? ent.len : ent.len - 1'b1;

  always_comb begin
    state_next = state;
    sem_re     = 1'b0;
    sem_raddr  = h_in_ok ? SW'(h_m1) : '0;
    sem_we     = 1'b0;
    sem_waddr  = sidx_q;
    sem_wdata  = ent;
    lnk_re     = 1'b0;
    lnk_raddr  = NW'(head_m1);
    lnk_we     = 1'b0;
    lnk_waddr  = NW'(caller_m1);
    lnk_wdata  = '0;
    res_load   = 1'b0;
    res_next   = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          sem_re     = 1'b1;
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (!h_ok_q) begin
          res_next.error_code = sqm_pkg::ERR_ARG;
          if (res_free) begin
            res_load   = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (op_q == sqm_pkg::OP_RESERVE) begin
          if (!caller_ok) begin
            res_next.error_code   = sqm_pkg::ERR_ARG;
            res_next.waiters_left = ent.len;
            if (res_free) begin
              res_load   = 1'b1;
              state_next = ST_IDLE;
            end
          end else begin
            lnk_we         = 1'b1;
            sem_we         = 1'b1;
            sem_wdata.head = tail_ok ? ent.head : caller_q;
            sem_wdata.tail = caller_q;
            sem_wdata.len  = len_inc;
            state_next     = ST_LINK;
          end
        end else if (op_q == sqm_pkg::OP_RELEASE) begin
          if (!head_ok) begin
            res_next.ok           = 1'b1;
            res_next.waiters_left = ent.len;
            if (res_free) begin
              res_load   = 1'b1;
              state_next = ST_IDLE;
            end
          end else begin
            lnk_re     = 1'b1;
            state_next = ST_POP;
          end
        end else begin
          res_next.error_code   = sqm_pkg::ERR_OP;
          res_next.waiters_left = ent.len;
          if (res_free) begin
            res_load   = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_LINK: begin
        lnk_waddr             = NW'(tail_m1);
        lnk_wdata             = caller_q;
        res_next.ok           = 1'b1;
        res_next.must_wait    = 1'b1;
        res_next.waiters_left = len_inc;
        if (res_free) begin
          lnk_we     = tail_ok;
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_POP: begin
        lnk_waddr              = NW'(head_m1);
        sem_wdata.head         = nxt_ok ? lnk_rdata : '0;
        sem_wdata.tail         = nxt_ok ? ent.tail : '0;
        sem_wdata.len          = len_dec;
        res_next.ok            = 1'b1;
        res_next.woken_process = ent.head;
        res_next.waiters_left  = len_dec;
        if (res_free) begin
          sem_we     = 1'b1;
          lnk_we     = 1'b1;
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q     <= req_type;
      h_ok_q   <= h_in_ok;
      sidx_q   <= SW'(h_m1);
      caller_q <= caller_process;
    end
    if (res_load) begin
      result <= res_next;
    end
  end

  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_LOOK))
    else $error("accepted request did not start a descriptor lookup");

  a_sem_write_state: assert property (@(posedge clk) disable iff (rst)
    sem_we |-> (state == ST_LOOK || state == ST_POP))
    else $error("descriptor write outside lookup or pop");

  a_pop_from_look: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP && $past(state) != ST_POP) |-> ($past(state) == ST_LOOK))
    else $error("pop entered without a lookup");

  a_err_not_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.error_code != sqm_pkg::ERR_NONE) |->
      (!result.ok && !result.must_wait && result.woken_process == '0))
    else $error("error result carries a completed operation");

  a_wait_or_wake: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.must_wait) |-> (result.woken_process == '0))
    else $error("result both queues and wakes a process");

endmodule
